[sv/ccbcd_pkg.sv]
package ccbcd_pkg;

    // one command word: a millisecond tick or a bcd load
    typedef struct packed {
        logic        action;
        logic [55:0] load_bcd;
    } cmd_word_t;

    // one report word: binary time plus the bcd image
    typedef struct packed {
        logic [9:0]  millis;
        logic [6:0]  seconds;
        logic [6:0]  minutes;
        logic [5:0]  hours;
        logic [5:0]  day_of_month;
        logic [4:0]  month_number;
        logic [6:0]  year_number;
        logic [55:0] bcd_image;
    } rpt_word_t;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam logic [9:0] MS_PER_SEC   = 10'd1000;
    localparam logic [9:0] MS_HALF      = 10'd500;
    localparam logic [6:0] SEC_PER_MIN  = 7'd60;
    localparam logic [6:0] MIN_PER_HOUR = 7'd60;
    localparam logic [5:0] HOUR_PER_DAY = 6'd24;
    localparam logic [4:0] MONTH_LAST   = 5'd12;
    localparam logic [4:0] MONTH_FEB    = 5'd2;
    localparam logic [6:0] YEAR_LAST    = 7'd99;
    localparam logic [7:0] YEAR_LAST_W  = 8'd99;
    localparam logic [5:0] DAYS_LONG    = 6'd31;
    localparam logic [5:0] DAYS_FEB_LEAP = 6'd29;

    localparam logic [3:0] MASK_SEC_MIN = 4'h7;
    localparam logic [3:0] MASK_HR_DAY  = 4'h3;
    localparam logic [3:0] MASK_MONTH   = 4'h1;
    localparam logic [3:0] MASK_YEAR    = 4'hf;

    // reciprocal of ten for values below 1029: (v * 205) >> 11
    localparam logic [14:0] RECIP_TEN = 15'd205;

    typedef logic [5:0] month_len_t [0:12];
    localparam month_len_t MONTH_LEN = '{
        6'd0, 6'd31, 6'd28, 6'd31, 6'd30, 6'd31, 6'd30,
        6'd31, 6'd31, 6'd30, 6'd31, 6'd30, 6'd31
    };

endpackage

[sv/calendar_clock_with_bcd_unit.sv]
// channel | direction | handshake              | payload
// cmd     | in        | cmd_valid / cmd_ready  | ccbcd_pkg::cmd_word_t
// rpt     | out       | rpt_valid / rpt_ready  | ccbcd_pkg::rpt_word_t
//
// one word per clock sustained while rpt_ready holds; a word waits in the command
// register and moves into the report register once that register has room.
// the carry chain, bcd decode and bcd encode all sit between those two registers.
// rst_n clears the calendar to all zeros and empties both registers.
// a stalled report holds the pipe; cmd_ready follows the report register's room.
module calendar_clock_with_bcd_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  ccbcd_pkg::cmd_word_t cmd,
    output logic                 rpt_valid,
    input  logic                 rpt_ready,
    output ccbcd_pkg::rpt_word_t rpt
);
    import ccbcd_pkg::*;

    cmd_word_t  cmd_reg;
    logic       cmd_valid_reg;
    rpt_word_t  rpt_reg;
    logic       rpt_valid_reg;

    logic [9:0] ms_reg,    ms_next;
    logic [6:0] sec_reg,   sec_next;
    logic [6:0] min_reg,   min_next;
    logic [5:0] hour_reg,  hour_next;
    logic [5:0] day_reg,   day_next;
    logic [4:0] month_reg, month_next;
    logic [6:0] year_reg,  year_next;

    rpt_word_t  rpt_next;
    logic       advance;
    logic [5:0] month_days;
    logic [7:0] year_load;
    logic [6:0] rsec;

    function automatic logic [7:0] bcd_dec(input logic [7:0] b, input logic [3:0] mask);
        logic [3:0] t;
        t = b[7:4] & mask;
        return 8'({t, 3'b000}) + 8'({t, 1'b0}) + 8'(b[3:0]);
    endfunction

    function automatic logic [7:0] bcd_enc(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 15'(v) * RECIP_TEN;
        q = p[14:11];
        r = v - (7'({q, 3'b000}) + 7'({q, 1'b0}));
        return {q, r[3:0]};
    endfunction

    assign advance   = cmd_valid_reg && (!rpt_valid_reg || rpt_ready);
    assign cmd_ready = !cmd_valid_reg || advance;
    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

    // length of the current month, months above twelve run 31 days
    always_comb
    begin
        priority if (month_reg > MONTH_LAST)
            month_days = DAYS_LONG;
        else if (month_reg == MONTH_FEB && year_reg[1:0] == 2'b00)
            month_days = DAYS_FEB_LEAP;
        else
            month_days = MONTH_LEN[month_reg[3:0]];
    end

    always_comb
    begin
        ms_next    = ms_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        year_load  = bcd_dec(cmd_reg.load_bcd[55:48], MASK_YEAR);
        unique case (cmd_reg.action)
            ACT_LOAD:
            begin
                ms_next    = '0;
                sec_next   = 7'(bcd_dec(cmd_reg.load_bcd[7:0],   MASK_SEC_MIN));
                min_next   = 7'(bcd_dec(cmd_reg.load_bcd[15:8],  MASK_SEC_MIN));
                hour_next  = 6'(bcd_dec(cmd_reg.load_bcd[23:16], MASK_HR_DAY));
                day_next   = 6'(bcd_dec(cmd_reg.load_bcd[39:32], MASK_HR_DAY));
                month_next = 5'(bcd_dec(cmd_reg.load_bcd[47:40], MASK_MONTH));
                year_next  = (year_load > YEAR_LAST_W) ? 7'd0 : year_load[6:0];
            end
            ACT_TICK:
            begin
                // carry ripples up; each wrap enables the next field
                if (ms_reg + 10'd1 < MS_PER_SEC)
                    ms_next = ms_reg + 10'd1;
                else
                begin
                    ms_next = '0;
                    if (sec_reg + 7'd1 < SEC_PER_MIN)
                        sec_next = sec_reg + 7'd1;
                    else
                    begin
                        sec_next = '0;
                        if (min_reg + 7'd1 < MIN_PER_HOUR)
                            min_next = min_reg + 7'd1;
                        else
                        begin
                            min_next = '0;
                            if (hour_reg + 6'd1 < HOUR_PER_DAY)
                                hour_next = hour_reg + 6'd1;
                            else
                            begin
                                hour_next = '0;
                                if (day_reg + 6'd1 <= month_days)
                                    day_next = day_reg + 6'd1;
                                else
                                begin
                                    day_next = 6'd1;
                                    if (month_reg + 5'd1 <= MONTH_LAST)
                                        month_next = month_reg + 5'd1;
                                    else
                                    begin
                                        month_next = 5'd1;
                                        year_next  = (year_reg + 7'd1 > YEAR_LAST) ?
                                                     7'd0 : year_reg + 7'd1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                ms_next = ms_reg;
            end
        endcase
    end

    // report word built from the updated time, bcd seconds rounded at half a second
    always_comb
    begin
        rsec = sec_next + ((ms_next >= MS_HALF) ? 7'd1 : 7'd0);
        rpt_next.millis       = ms_next;
        rpt_next.seconds      = sec_next;
        rpt_next.minutes      = min_next;
        rpt_next.hours        = hour_next;
        rpt_next.day_of_month = day_next;
        rpt_next.month_number = month_next;
        rpt_next.year_number  = year_next;
        rpt_next.bcd_image    = {bcd_enc(year_next), bcd_enc(7'(month_next)),
                                 bcd_enc(7'(day_next)), 8'h00, bcd_enc(7'(hour_next)),
                                 bcd_enc(min_next), bcd_enc(rsec)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rpt_valid_reg <= 1'b0;
            ms_reg        <= '0;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= '0;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
        end
        else
        begin
            if (cmd_ready)
                cmd_valid_reg <= cmd_valid;
            if (advance)
                rpt_valid_reg <= 1'b1;
            else if (rpt_ready)
                rpt_valid_reg <= 1'b0;
            if (advance)
            begin
                ms_reg    <= ms_next;
                sec_reg   <= sec_next;
                min_reg   <= min_next;
                hour_reg  <= hour_next;
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
            cmd_reg <= cmd;
        if (advance)
            rpt_reg <= rpt_next;
    end

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ccbcd_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;
    localparam int PRINT_CAP   = 40;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    cmd_word_t cmd;
    logic      rpt_valid;
    logic      rpt_ready;
    rpt_word_t rpt;

    // calendar as the block should hold it
    logic [9:0] cal_ms;
    logic [6:0] cal_sec;
    logic [6:0] cal_min;
    logic [5:0] cal_hour;
    logic [5:0] cal_day;
    logic [4:0] cal_month;
    logic [6:0] cal_year;

    rpt_word_t pending_times[$];
    int        error_count = 0;
    bit        idle_on = 1'b1;

    calendar_clock_with_bcd_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int month_length(logic [4:0] m, logic [6:0] y);
        if (m > MONTH_LAST)
            return 31;
        if (m == MONTH_FEB && (y % 4) == 0)
            return 29;
        case (m)
            5'd0:                       return 0;
            5'd2:                       return 28;
            5'd4, 5'd6, 5'd9, 5'd11:    return 30;
            default:                    return 31;
        endcase
    endfunction

    function automatic logic [7:0] to_bcd(int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic int bcd_value(logic [7:0] b, logic [3:0] tens_mask);
        return int'(b[7:4] & tens_mask) * 10 + int'(b[3:0]);
    endfunction

    function automatic void reset_calendar();
        cal_ms    = '0;
        cal_sec   = '0;
        cal_min   = '0;
        cal_hour  = '0;
        cal_day   = '0;
        cal_month = '0;
        cal_year  = '0;
    endfunction

    // full carry chain for one millisecond
    function automatic void step_millisecond();
        cal_ms = cal_ms + 10'd1;
        if (cal_ms >= MS_PER_SEC)
        begin
            cal_ms  = '0;
            cal_sec = cal_sec + 7'd1;
            if (cal_sec >= SEC_PER_MIN)
            begin
                cal_sec = '0;
                cal_min = cal_min + 7'd1;
                if (cal_min >= MIN_PER_HOUR)
                begin
                    cal_min  = '0;
                    cal_hour = cal_hour + 6'd1;
                    if (cal_hour >= HOUR_PER_DAY)
                    begin
                        cal_hour = '0;
                        cal_day  = cal_day + 6'd1;
                        if (int'(cal_day) > month_length(cal_month, cal_year))
                        begin
                            cal_day   = 6'd1;
                            cal_month = cal_month + 5'd1;
                            if (cal_month > MONTH_LAST)
                            begin
                                cal_month = 5'd1;
                                cal_year  = cal_year + 7'd1;
                                if (cal_year > YEAR_LAST)
                                    cal_year = '0;
                            end
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void load_from_bcd(logic [55:0] img);
        int yr;
        yr        = bcd_value(img[55:48], MASK_YEAR);
        cal_ms    = '0;
        cal_sec   = 7'(bcd_value(img[7:0], MASK_SEC_MIN));
        cal_min   = 7'(bcd_value(img[15:8], MASK_SEC_MIN));
        cal_hour  = 6'(bcd_value(img[23:16], MASK_HR_DAY));
        cal_day   = 6'(bcd_value(img[39:32], MASK_HR_DAY));
        cal_month = 5'(bcd_value(img[47:40], MASK_MONTH));
        cal_year  = (yr > 99) ? 7'd0 : 7'(yr);
    endfunction

    function automatic rpt_word_t time_report();
        rpt_word_t r;
        int        rounded;
        rounded        = int'(cal_sec) + ((cal_ms >= MS_HALF) ? 1 : 0);
        r.millis       = cal_ms;
        r.seconds      = cal_sec;
        r.minutes      = cal_min;
        r.hours        = cal_hour;
        r.day_of_month = cal_day;
        r.month_number = cal_month;
        r.year_number  = cal_year;
        r.bcd_image    = {to_bcd(int'(cal_year)), to_bcd(int'(cal_month)),
                          to_bcd(int'(cal_day)), 8'h00, to_bcd(int'(cal_hour)),
                          to_bcd(int'(cal_min)), to_bcd(rounded)};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < PRINT_CAP)
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic send_word(input logic act, input logic [55:0] img);
        cmd_word_t w;
        w.action   = act;
        w.load_bcd = img;
        if (idle_on && $urandom_range(0, 99) < 15)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        if (act == ACT_LOAD)
            load_from_bcd(img);
        else
            step_millisecond();
        pending_times.push_back(time_report());
    endtask

    function automatic logic [55:0] noise56();
        return 56'({$urandom(), $urandom()});
    endfunction

    task automatic send_tick();
        send_word(ACT_TICK, noise56());
    endtask

    task automatic test_reset_ticks();
        repeat (3) send_tick();
    endtask

    // masks on tens digits, non-decimal digits, year above 99
    task automatic test_load_decode();
        logic [55:0] images [7];
        images[0] = 56'h00_00_00_00_00_00_00;
        images[1] = 56'hff_ff_ff_ff_ff_ff_ff;
        images[2] = 56'h99_12_31_5a_23_59_59;
        images[3] = 56'ha5_e0_c9_00_c3_f9_8f;
        images[4] = 56'h9f_1f_3f_00_3f_7f_7f;
        images[5] = 56'h6f_10_01_ff_00_00_00;
        images[6] = 56'h00_00_00_00_00_00_01;
        foreach (images[i])
        begin
            send_word(ACT_LOAD, images[i]);
            send_tick();
        end
    endtask

    function automatic logic [55:0] random_date();
        return {to_bcd($urandom_range(0, 99)), to_bcd($urandom_range(1, 12)),
                to_bcd($urandom_range(1, 31)), 8'($urandom()),
                to_bcd($urandom_range(0, 23)), to_bcd($urandom_range(0, 59)),
                to_bcd($urandom_range(0, 59))};
    endfunction

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 15)
                send_word(ACT_LOAD, ($urandom_range(0, 1) == 1) ? random_date() : noise56());
            else
                send_tick();
        end
    endtask

    // load just before a boundary, then tick toward it
    task automatic test_carry_chain(int runs, int ticks);
        logic [4:0] mon;
        int         yr;
        int         len;
        int         day;
        logic [7:0] sec_b;
        logic [7:0] min_b;
        logic [7:0] hour_b;
        for (int r = 0; r < runs; r++)
        begin
            mon = 5'($urandom_range(0, 13));
            yr  = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99);
            len = month_length(mon, 7'(yr));
            case ($urandom_range(0, 3))
                0:       day = $urandom_range(0, 31);
                1:       day = (len > 0) ? len - 1 : 0;
                default: day = len;
            endcase
            sec_b  = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : to_bcd(59);
            min_b  = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : to_bcd(59);
            hour_b = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : to_bcd(23);
            send_word(ACT_LOAD, {to_bcd(yr), to_bcd(int'(mon)), to_bcd(day),
                                 8'($urandom()), hour_b, min_b, sec_b});
            repeat (ticks) send_tick();
        end
    endtask

    // plain ticks, carries the millisecond count past the half second
    task automatic test_tick_run(int count);
        repeat (count) send_tick();
    endtask

    initial
    begin
        rpt_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 99) < 12)
            begin
                rpt_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            rpt_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        rpt_word_t want;
        if (rst_n && rpt_valid && rpt_ready)
        begin
            if (pending_times.size() == 0)
                report_mismatch("unexpected word", 64'(rpt.bcd_image), 64'h0);
            else
            begin
                want = pending_times.pop_front();
                if (rpt.millis !== want.millis)
                    report_mismatch("millis", 64'(rpt.millis), 64'(want.millis));
                if (rpt.seconds !== want.seconds)
                    report_mismatch("seconds", 64'(rpt.seconds), 64'(want.seconds));
                if (rpt.minutes !== want.minutes)
                    report_mismatch("minutes", 64'(rpt.minutes), 64'(want.minutes));
                if (rpt.hours !== want.hours)
                    report_mismatch("hours", 64'(rpt.hours), 64'(want.hours));
                if (rpt.day_of_month !== want.day_of_month)
                    report_mismatch("day_of_month", 64'(rpt.day_of_month),
                                    64'(want.day_of_month));
                if (rpt.month_number !== want.month_number)
                    report_mismatch("month_number", 64'(rpt.month_number),
                                    64'(want.month_number));
                if (rpt.year_number !== want.year_number)
                    report_mismatch("year_number", 64'(rpt.year_number),
                                    64'(want.year_number));
                if (rpt.bcd_image !== want.bcd_image)
                    report_mismatch("bcd_image", 64'(rpt.bcd_image), 64'(want.bcd_image));
            end
        end
    end

    // cycles in which no word moves on either side
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rpt_valid && rpt_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        reset_calendar();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_ticks();
        test_load_decode();
        test_random_mix(20);
        test_carry_chain(1, 400);

        // full rate on both sides from here on
        idle_on = 1'b0;
        test_tick_run(110);
        test_random_mix(10);

        cmd_valid <= 1'b0;
        while (pending_times.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[calendar_clock_with_bcd_unit.f]
sv/ccbcd_pkg.sv
sv/calendar_clock_with_bcd_unit.sv
test/tb_top.sv
